[sv/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, constants and helpers of the rotation matrix to quaternion
// pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int SQRT_STAGES = 16;
    localparam int DIV_STAGES  = 16;
    localparam int LANES       = 3;

    localparam logic [15:0] ROOT_MAX = 16'd46341;
    localparam logic signed [18:0] ONE_Q14 = 19'sd16384;

    typedef logic signed [15:0] q14_t;
    typedef logic signed [16:0] diff_t;
    typedef logic [1:0]         slot_t;

    localparam slot_t SLOT_X = 2'd0;
    localparam slot_t SLOT_Y = 2'd1;
    localparam slot_t SLOT_Z = 2'd2;
    localparam slot_t SLOT_W = 2'd3;

    typedef struct packed {
        q14_t r00; q14_t r01; q14_t r02;
        q14_t r10; q14_t r11; q14_t r12;
        q14_t r20; q14_t r21; q14_t r22;
    } mat_t;

    // Side information that rides along with the square root.
    typedef struct packed {
        slot_t          half_slot;
        diff_t [LANES-1:0] d;
    } side_t;

    typedef struct packed {
        logic [30:0] n;
        logic [15:0] q;
        logic        neg;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic [16:0]       dvs;
        logic              zero;
        logic [15:0]       half;
        slot_t             half_slot;
    } dstg_t;

    // Quotient bit 15 set means the magnitude reached 32768 and saturates.
    function automatic q14_t lane_value(input lane_t l, input logic zero);
        q14_t r;
        if (zero)
            r = '0;
        else if (l.q[15])
            r = l.neg ? 16'sh8000 : 16'sh7fff;
        else if (l.neg)
            r = q14_t'(-$signed({1'b0, l.q[14:0]}));
        else
            r = q14_t'({1'b0, l.q[14:0]});
        return r;
    endfunction

endpackage

[sv/rmq_front.sv]
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection, square root argument and the three difference terms.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rmq_pkg::mat_t   mat,
    output logic            out_valid,
    output logic [16:0]     rad,
    output rmq_pkg::side_t  side
);

    logic signed [18:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [18:0] trace;
    logic signed [18:0] arg;
    rmq_pkg::side_t     side_next;
    logic [16:0]        rad_next;
    logic               valid_reg;
    logic [16:0]        rad_reg;
    rmq_pkg::side_t     side_reg;

    assign e00 = 19'(mat.r00);
    assign e01 = 19'(mat.r01);
    assign e02 = 19'(mat.r02);
    assign e10 = 19'(mat.r10);
    assign e11 = 19'(mat.r11);
    assign e12 = 19'(mat.r12);
    assign e20 = 19'(mat.r20);
    assign e21 = 19'(mat.r21);
    assign e22 = 19'(mat.r22);

    assign trace = e00 + e11 + e22;

    always_comb
    begin
        if (trace > 0)
        begin
            side_next.half_slot = rmq_pkg::SLOT_W;
            arg = rmq_pkg::ONE_Q14 + trace;
            side_next.d[0] = 17'(e12 - e21);
            side_next.d[1] = 17'(e20 - e02);
            side_next.d[2] = 17'(e01 - e10);
        end
        else if ((e11 > e00 && e22 > e11) || (!(e11 > e00) && e22 > e00))
        begin
            side_next.half_slot = rmq_pkg::SLOT_Z;
            arg = rmq_pkg::ONE_Q14 + e22 - e00 - e11;
            side_next.d[0] = 17'(e20 + e02);
            side_next.d[1] = 17'(e21 + e12);
            side_next.d[2] = 17'(e01 - e10);
        end
        else if (e11 > e00)
        begin
            side_next.half_slot = rmq_pkg::SLOT_Y;
            arg = rmq_pkg::ONE_Q14 + e11 - e22 - e00;
            side_next.d[0] = 17'(e12 + e21);
            side_next.d[1] = 17'(e10 + e01);
            side_next.d[2] = 17'(e20 - e02);
        end
        else
        begin
            side_next.half_slot = rmq_pkg::SLOT_X;
            arg = rmq_pkg::ONE_Q14 + e00 - e11 - e22;
            side_next.d[0] = 17'(e01 + e10);
            side_next.d[1] = 17'(e02 + e20);
            side_next.d[2] = 17'(e12 - e21);
        end
        // A matrix that is not orthonormal can drive the argument negative.
        rad_next = arg[18] ? 17'd0 : arg[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign rad       = rad_reg;
    assign side      = side_reg;

endmodule

[sv/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [16:0]     rad,
    input  rmq_pkg::side_t  in_side,
    output logic            out_valid,
    output logic [15:0]     root,
    output rmq_pkg::side_t  out_side
);

    localparam int N = rmq_pkg::SQRT_STAGES;

    logic           valid_reg [N];
    logic [19:0]    rem_reg   [N];
    logic [15:0]    root_reg  [N];
    logic [31:0]    v_reg     [N];
    rmq_pkg::side_t side_reg  [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic           vin;
            logic [19:0]    rin;
            logic [15:0]    oin;
            logic [31:0]    xin;
            rmq_pkg::side_t sin;
            logic [19:0]    remx;
            logic [19:0]    trial;
            logic [19:0]    rem_next;
            logic [15:0]    root_next;

            if (k == 0)
            begin : g_first
                assign vin = in_valid;
                assign rin = '0;
                assign oin = '0;
                assign xin = {1'b0, rad, 14'b0};
                assign sin = in_side;
            end
            else
            begin : g_rest
                assign vin = valid_reg[k-1];
                assign rin = rem_reg[k-1];
                assign oin = root_reg[k-1];
                assign xin = v_reg[k-1];
                assign sin = side_reg[k-1];
            end

            always_comb
            begin
                remx  = {rin[17:0], xin[2*(N-1-k)+1 -: 2]};
                trial = {2'b00, oin, 2'b01};
                if (remx >= trial)
                begin
                    rem_next  = remx - trial;
                    root_next = {oin[14:0], 1'b1};
                end
                else
                begin
                    rem_next  = remx;
                    root_next = {oin[14:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (en)
                    valid_reg[k] <= vin;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    v_reg[k]    <= xin;
                    side_reg[k] <= sin;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign root      = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

[sv/rmq_div.sv]
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider giving d/(2s) rounded in Q14.
// ----------------------------------------------------------------------------
module rmq_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [15:0]     root,
    input  rmq_pkg::side_t  in_side,
    output logic            out_valid,
    output rmq_pkg::dstg_t  out_stage
);

    localparam int N = rmq_pkg::DIV_STAGES;
    localparam int L = rmq_pkg::LANES;

    rmq_pkg::dstg_t prep_next;
    rmq_pkg::dstg_t prep_reg;
    logic           prep_valid_reg;
    rmq_pkg::dstg_t stg_reg   [N];
    logic           valid_reg [N];

    // Numerator |d|*16384 + s against divisor 2s gives round half away.
    always_comb
    begin
        logic [16:0] mag;
        logic [16:0] one_more;
        mag      = '0;
        one_more = {1'b0, root} + 17'd1;
        for (int l = 0; l < L; l++)
        begin
            prep_next.lane[l].neg = in_side.d[l][16];
            mag = in_side.d[l][16] ? 17'(-in_side.d[l]) : 17'(in_side.d[l]);
            prep_next.lane[l].n = {mag, 14'b0} + {15'b0, root};
            prep_next.lane[l].q = '0;
        end
        prep_next.dvs       = {root, 1'b0};
        prep_next.zero      = (root == 16'd0);
        prep_next.half      = one_more[16:1];
        prep_next.half_slot = in_side.half_slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (en)
            prep_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            rmq_pkg::dstg_t sin;
            rmq_pkg::dstg_t snext;
            logic           vin;

            if (k == 0)
            begin : g_first
                assign sin = prep_reg;
                assign vin = prep_valid_reg;
            end
            else
            begin : g_rest
                assign sin = stg_reg[k-1];
                assign vin = valid_reg[k-1];
            end

            always_comb
            begin
                logic [31:0] dd;
                logic [31:0] rx;
                dd    = {15'b0, sin.dvs} << (N - 1 - k);
                rx    = '0;
                snext = sin;
                for (int l = 0; l < L; l++)
                begin
                    rx = {1'b0, sin.lane[l].n};
                    if (rx >= dd)
                    begin
                        rx = rx - dd;
                        snext.lane[l].q[N-1-k] = 1'b1;
                    end
                    snext.lane[l].n = rx[30:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (en)
                    valid_reg[k] <= vin;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    stg_reg[k] <= snext;
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign out_stage = stg_reg[N-1];

endmodule

[sv/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shoemake conversion of a Q2.14 rotation matrix into a Q2.14 quaternion.
// ----------------------------------------------------------------------------
// Channel  Dir  Bits  Content
// s_*      in   144   r00 r01 r02 r10 r11 r12 r20 r21 r22, signed Q2.14
// m_*      out   64   qx qy qz qw, signed Q2.14, saturated
//
// One request is taken every cycle unless the output stalls. The path is one
// setup stage, 16 square root stages, one divider setup stage, 16 divider
// stages and the output register. Throughput is set by the fully pipelined
// root and divider. The whole pipeline holds while a result waits at the
// output; s_tready is low only then. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata    // qx, qy, qz, qw
);

    logic                en;
    rmq_pkg::mat_t       mat;
    logic                fr_valid;
    logic [16:0]         fr_rad;
    rmq_pkg::side_t      fr_side;
    logic                sq_valid;
    logic [15:0]         sq_root;
    rmq_pkg::side_t      sq_side;
    logic                dv_valid;
    rmq_pkg::dstg_t      dv_stage;
    rmq_pkg::q14_t       l0, l1, l2, hv;
    logic [63:0]         data_next;
    logic                out_valid_reg;
    logic [63:0]         data_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign mat.r00 = s_tdata[15:0];
    assign mat.r01 = s_tdata[31:16];
    assign mat.r02 = s_tdata[47:32];
    assign mat.r10 = s_tdata[63:48];
    assign mat.r11 = s_tdata[79:64];
    assign mat.r12 = s_tdata[95:80];
    assign mat.r20 = s_tdata[111:96];
    assign mat.r21 = s_tdata[127:112];
    assign mat.r22 = s_tdata[143:128];

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .mat       (mat),
        .out_valid (fr_valid),
        .rad       (fr_rad),
        .side      (fr_side)
    );

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .rad       (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_stage (dv_stage)
    );

    assign l0 = rmq_pkg::lane_value(dv_stage.lane[0], dv_stage.zero);
    assign l1 = rmq_pkg::lane_value(dv_stage.lane[1], dv_stage.zero);
    assign l2 = rmq_pkg::lane_value(dv_stage.lane[2], dv_stage.zero);
    assign hv = dv_stage.half;

    // Lane order follows the cyclic j, k choice of each branch.
    always_comb
    begin
        case (dv_stage.half_slot)
            rmq_pkg::SLOT_X: data_next = {l2, l1, l0, hv};
            rmq_pkg::SLOT_Y: data_next = {l2, l0, hv, l1};
            rmq_pkg::SLOT_Z: data_next = {l2, hv, l1, l0};
            default:         data_next = {hv, l2, l1, l0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;

`ifndef NO_ASSERTIONS
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> sq_root <= rmq_pkg::ROOT_MAX)
        else $error("square root above its largest possible value");

    a_half_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && !dv_stage.zero |-> dv_stage.half >= 16'd64)
        else $error("nonzero root gave a tiny half component");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_stage) && $stable(dv_valid))
        else $error("pipeline moved during a stall");

    a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");
`endif

endmodule
